// ----- sv/kcm_pkg.sv -----
// Shared types and constants of the k-means convergence measure.
package kcm_pkg;

  localparam int VAL_W      = 24;
  localparam int MAG_W      = 24;
  localparam int SQ_W       = 48;
  localparam int SUM_W      = 63;
  localparam int CHG_W      = 17;
  localparam int QUO_W      = 16;
  localparam int PASS_W     = 16;
  localparam int VL_W       = 6;
  localparam int CC_W       = 7;
  localparam int THR_W      = 41;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_SHIFT = 24;

  localparam logic [SUM_W-1:0]  SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [CHG_W-1:0]  ONE_Q16         = 17'h10000;
  localparam logic [PASS_W-1:0] EARLY_PASS_LAST = 16'd2;

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_THRESHOLD = 2'd2;

  localparam logic [VL_W-1:0]  VL_RESET  = 6'd16;
  localparam logic [CC_W-1:0]  CC_RESET  = 7'd64;
  localparam logic [THR_W-1:0] THR_RESET = 41'd16777216;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] cur;
    logic [SUM_W-1:0] prev;
    logic             early;
  } kcm_entry_t;

  typedef struct packed {
    logic       push;
    kcm_entry_t entry;
  } kcm_push_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_CHECK,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

// ----- sv/kcm_front.sv -----
// Front part: takes coordinate words, squares and sums them, closes centres and passes.
module kcm_front #(
  parameter int MAX_VECTOR_LENGTH = 32,
  parameter int MAX_CENTERS       = 64,
  parameter int LEN_W             = $clog2(MAX_VECTOR_LENGTH + 1),
  parameter int CNT_W             = $clog2(MAX_CENTERS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kcm_pkg::VAL_W-1:0]     in_current_value,
  input  logic [kcm_pkg::VAL_W-1:0]     in_previous_value,
  input  logic [kcm_pkg::PASS_W-1:0]    in_pass_number,
  input  logic [LEN_W-1:0]              eff_len,
  input  logic [CNT_W-1:0]              eff_cnt,
  input  logic [kcm_pkg::THR_W-1:0]     threshold,
  output kcm_pkg::kcm_push_t            q_push,
  input  logic                          q_full
);
  import kcm_pkg::*;

  localparam int EW  = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
  localparam int CW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int CSW = SQ_W + $clog2(MAX_VECTOR_LENGTH);

  logic [EW-1:0]    elem_r, elem_nxt;
  logic [CW-1:0]    cidx_r, cidx_nxt;
  logic             v1_r, v2_r, v3_r;
  logic [MAG_W-1:0] mag1_r;
  logic             le1_r, lc1_r, early1_r;
  logic [SQ_W-1:0]  sq2_r;
  logic             le2_r, lc2_r, early2_r;
  logic [CSW-1:0]   csum_r;
  logic [CSW-1:0]   dsum3_r;
  logic             lc3_r, early3_r;
  logic [SUM_W-1:0] pass_r, prev_pass_r;

  logic             adv, accept, last_e, last_c;
  logic [VAL_W:0]   diff, diff_neg;
  logic [MAG_W-1:0] mag;
  logic [CSW-1:0]   acc;
  logic [CSW-1:0]   add_val;
  logic [SUM_W:0]   psum_wide;
  logic [SUM_W-1:0] psum_new;

  always_comb begin
    adv      = !(v3_r && lc3_r && q_full);
    in_stall = !adv;
    accept   = in_valid && adv;

    diff     = {in_current_value[VAL_W-1], in_current_value}
             - {in_previous_value[VAL_W-1], in_previous_value};
    diff_neg = -diff;
    mag      = diff[VAL_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

    last_e = (32'(elem_r) + 32'd1) >= 32'(eff_len);
    last_c = last_e && ((32'(cidx_r) + 32'd1) >= 32'(eff_cnt));

    elem_nxt = elem_r;
    cidx_nxt = cidx_r;
    if (accept) begin
      if (last_e) begin
        elem_nxt = '0;
        if (last_c) begin
          cidx_nxt = '0;
        end else begin
          cidx_nxt = cidx_r + 1'b1;
        end
      end else begin
        elem_nxt = elem_r + 1'b1;
      end
    end

    acc       = csum_r + CSW'(sq2_r);
    add_val   = ((SUM_W + 1)'(dsum3_r) > (SUM_W + 1)'(threshold)) ? dsum3_r : '0;
    psum_wide = {1'b0, pass_r} + (SUM_W + 1)'(add_val);
    psum_new  = psum_wide[SUM_W] ? SUM_MAX : psum_wide[SUM_W-1:0];

    q_push.push        = v3_r && lc3_r && adv;
    q_push.entry.cur   = psum_new;
    q_push.entry.prev  = prev_pass_r;
    q_push.entry.early = early3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      elem_r      <= '0;
      cidx_r      <= '0;
      csum_r      <= '0;
      pass_r      <= '0;
      prev_pass_r <= '0;
    end else if (adv) begin
      v1_r   <= accept;
      v2_r   <= v1_r;
      v3_r   <= v2_r && le2_r;
      elem_r <= elem_nxt;
      cidx_r <= cidx_nxt;
      if (v2_r) begin
        csum_r <= le2_r ? '0 : acc;
      end
      if (v3_r) begin
        if (lc3_r) begin
          pass_r      <= '0;
          prev_pass_r <= psum_new;
        end else begin
          pass_r <= psum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag1_r   <= mag;
      le1_r    <= last_e;
      lc1_r    <= last_c;
      early1_r <= (in_pass_number <= EARLY_PASS_LAST);
      sq2_r    <= SQ_W'(mag1_r) * SQ_W'(mag1_r);
      le2_r    <= le1_r;
      lc2_r    <= lc1_r;
      early2_r <= early1_r;
      dsum3_r  <= acc;
      lc3_r    <= lc2_r;
      early3_r <= early2_r;
    end
  end

endmodule

// ----- sv/kcm_queue.sv -----
// Short queue of finished pass totals between the front and back parts.
module kcm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kcm_pkg::kcm_push_t   wr,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output kcm_pkg::kcm_entry_t  head
);
  import kcm_pkg::*;

  kcm_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_CNT_W-1:0] count_r;

  always_comb begin
    full  = (count_r == Q_CNT_W'(Q_DEPTH));
    empty = (count_r == '0);
    head  = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (wr.push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr.push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !wr.push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wp_r] <= wr.entry;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue count beyond depth");

endmodule

// ----- sv/kcm_back.sv -----
// Back part: turns a pass total into the normalised change and holds the result word.
module kcm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  kcm_pkg::kcm_entry_t        q_head,
  output logic                       q_pop,
  input  logic [kcm_pkg::SUM_W-1:0]  limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kcm_pkg::SUM_W-1:0]  out_convergence_sum,
  output logic [kcm_pkg::CHG_W-1:0]  out_normalized_change,
  output logic                       out_saturated
);
  import kcm_pkg::*;

  back_state_t          state_r, state_nxt;
  logic [SUM_W-1:0]     cur_r, cur_nxt;
  logic [SUM_W-1:0]     prev_r, prev_nxt;
  logic                 early_r, early_nxt;
  logic                 over_r, over_nxt;
  logic                 sat_r, sat_nxt;
  logic [SUM_W-1:0]     delta_r, delta_nxt;
  logic [SUM_W-1:0]     big_r, big_nxt;
  logic [SUM_W-1:0]     rem_r, rem_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CHG_W-1:0]     chg_r, chg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]     out_sum_r;
  logic [CHG_W-1:0]     out_chg_r;
  logic                 out_sat_r;

  logic                 load, gt, step_bit;
  logic [SUM_W:0]       shifted;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    early_nxt = early_r;
    over_nxt  = over_r;
    sat_nxt   = sat_r;
    delta_nxt = delta_r;
    big_nxt   = big_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    chg_nxt   = chg_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    gt        = cur_r > prev_r;
    shifted   = {rem_r, 1'b0};
    step_bit  = shifted >= {1'b0, big_r};

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head.cur;
          prev_nxt  = q_head.prev;
          early_nxt = q_head.early;
          state_nxt = BK_PREP;
        end
      end
      BK_PREP: begin
        delta_nxt = gt ? (cur_r - prev_r) : (prev_r - cur_r);
        big_nxt   = gt ? cur_r : prev_r;
        over_nxt  = cur_r > limit;
        sat_nxt   = (cur_r == SUM_MAX);
        state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        if (early_r) begin
          chg_nxt   = ONE_Q16;
          state_nxt = BK_FIN;
        end else if (!over_r) begin
          chg_nxt   = '0;
          state_nxt = BK_FIN;
        end else if (delta_r >= big_r) begin
          chg_nxt   = ONE_Q16;
          state_nxt = BK_FIN;
        end else begin
          rem_nxt   = delta_r;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_bit) begin
          rem_nxt = SUM_W'(shifted - {1'b0, big_r});
        end else begin
          rem_nxt = shifted[SUM_W-1:0];
        end
        quo_nxt = {quo_r[QUO_W-2:0], step_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          chg_nxt   = CHG_W'(quo_nxt);
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    out_valid             = out_valid_r;
    out_convergence_sum   = out_sum_r;
    out_normalized_change = out_chg_r;
    out_saturated         = out_sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    early_r <= early_nxt;
    over_r  <= over_nxt;
    sat_r   <= sat_nxt;
    delta_r <= delta_nxt;
    big_r   <= big_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    chg_r   <= chg_nxt;
    if (load) begin
      out_sum_r <= cur_r;
      out_chg_r <= chg_r;
      out_sat_r <= sat_r;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> rem_r < big_r) else $error("divider remainder not below divisor");
  a_change_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_FIN |-> chg_r <= ONE_Q16) else $error("normalised change above one");
  a_div_only_when_needed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> (over_r && !early_r)) else $error("division on a short-cut pass");

endmodule

// ----- sv/kcm_convergence_measure_top.sv -----
// Top level of the k-means convergence measure: configuration, front, queue and back.
//
//  channel | direction | handshake          | words
//  in      | input     | in_valid/in_stall   | current, previous coordinate, pass number
//  out     | output    | out_valid/out_stall | pass total, normalised change, saturated
//  cfg     | input     | cfg_wr_en           | register index and data
//
// One coordinate word is taken per cycle unless in_stall is high; the square and sum
// work is pipelined. The back part takes each finished pass in turn, with a
// shift-subtract divider where needed; a two-entry queue lets the front run on meanwhile.
// in_stall rises only while a finished pass waits for a free queue entry.
// Reset loads the register defaults and clears all sums; there is no clearing pass.
module kmeans_convergence_measure #(
  parameter int MAX_VECTOR_LENGTH = 32,
  parameter int MAX_CENTERS       = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kcm_pkg::VAL_W-1:0]     in_current_value,
  input  logic [kcm_pkg::VAL_W-1:0]     in_previous_value,
  input  logic [kcm_pkg::PASS_W-1:0]    in_pass_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kcm_pkg::SUM_W-1:0]     out_convergence_sum,
  output logic [kcm_pkg::CHG_W-1:0]     out_normalized_change,
  output logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [kcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcm_pkg::THR_W-1:0]     cfg_data
);
  import kcm_pkg::*;

  localparam int LEN_W = $clog2(MAX_VECTOR_LENGTH + 1);
  localparam int CNT_W = $clog2(MAX_CENTERS + 1);

  logic [VL_W-1:0]  vl_r;
  logic [CC_W-1:0]  cc_r;
  logic [THR_W-1:0] thr_r;
  logic [LEN_W-1:0] eff_len;
  logic [CNT_W-1:0] eff_cnt;
  logic [SUM_W-1:0] limit;

  kcm_push_t  q_push;
  kcm_entry_t q_head;
  logic       q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r  <= VL_RESET;
      cc_r  <= CC_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VECTOR_LENGTH:    vl_r  <= cfg_data[VL_W-1:0];
        CFG_CENTER_COUNT:     cc_r  <= cfg_data[CC_W-1:0];
        CFG_CENTER_THRESHOLD: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vl_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(vl_r) > MAX_VECTOR_LENGTH) begin
      eff_len = LEN_W'(MAX_VECTOR_LENGTH);
    end else begin
      eff_len = LEN_W'(vl_r);
    end
    if (cc_r == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(cc_r) > MAX_CENTERS) begin
      eff_cnt = CNT_W'(MAX_CENTERS);
    end else begin
      eff_cnt = CNT_W'(cc_r);
    end
    limit = SUM_W'(eff_cnt) << FRAC_SHIFT;
  end

  kcm_front #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
    .MAX_CENTERS       (MAX_CENTERS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_current_value  (in_current_value),
    .in_previous_value (in_previous_value),
    .in_pass_number    (in_pass_number),
    .eff_len           (eff_len),
    .eff_cnt           (eff_cnt),
    .threshold         (thr_r),
    .q_push            (q_push),
    .q_full            (q_full)
  );

  kcm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  kcm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_head                (q_head),
    .q_pop                 (q_pop),
    .limit                 (limit),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_convergence_sum   (out_convergence_sum),
    .out_normalized_change (out_normalized_change),
    .out_saturated         (out_saturated)
  );

endmodule

// ----- tb/kcm_checker.sv -----
// Checker for the convergence measure: watches the channels, predicts each pass result and compares.
module kcm_checker #(
  parameter int MAX_LEN = 32,
  parameter int MAX_CTR = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [kcm_pkg::VAL_W-1:0]     in_current_value,
  input  logic [kcm_pkg::VAL_W-1:0]     in_previous_value,
  input  logic [kcm_pkg::PASS_W-1:0]    in_pass_number,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [kcm_pkg::SUM_W-1:0]     out_convergence_sum,
  input  logic [kcm_pkg::CHG_W-1:0]     out_normalized_change,
  input  logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [kcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcm_pkg::THR_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kcm_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic [CHG_W-1:0] change;
    logic             sat;
  } pass_result_t;

  logic [VL_W-1:0]  vec_len;
  logic [CC_W-1:0]  ctr_cnt;
  logic [THR_W-1:0] ctr_thr;
  int               elem_idx;
  int               ctr_idx;
  logic [SUM_W-1:0] ctr_acc;
  logic [SUM_W-1:0] pass_acc;
  logic [SUM_W-1:0] last_pass_acc;
  pass_result_t     pass_results_due[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int span(input int v, input int ceiling);
    return (v == 0) ? 1 : ((v > ceiling) ? ceiling : v);
  endfunction

  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic logic [CHG_W-1:0] change_q16(input logic [63:0] d, input logic [63:0] m);
    logic [63:0]      r;
    logic [QUO_W-1:0] q;
    int               i;
    if (d >= m) return ONE_Q16;
    r = d;
    q = '0;
    for (i = 0; i < QUO_W; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= m) begin
        r = r - m;
        q[0] = 1'b1;
      end
    end
    return {1'b0, q};
  endfunction

  function automatic bit fold_coordinate(input logic [VAL_W-1:0] c, input logic [VAL_W-1:0] p,
                                         input logic [PASS_W-1:0] pn, output pass_result_t r);
    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]        mag;
    logic [63:0]           sq;
    logic [63:0]           limit;
    logic [63:0]           delta;
    logic [63:0]           big;
    int                    len;
    int                    cnt;
    r = '0;
    len = span(int'(vec_len), MAX_LEN);
    cnt = span(int'(ctr_cnt), MAX_CTR);
    diff = $signed({c[VAL_W-1], c}) - $signed({p[VAL_W-1], p});
    mag = (diff < 0) ? -diff : diff;
    sq = 64'(mag) * 64'(mag);
    ctr_acc = add_clamped(ctr_acc, sq[SUM_W-1:0]);
    if (elem_idx + 1 < len) begin
      elem_idx++;
      return 1'b0;
    end
    elem_idx = 0;
    if (ctr_acc > SUM_W'(ctr_thr)) pass_acc = add_clamped(pass_acc, ctr_acc);
    ctr_acc = '0;
    if (ctr_idx + 1 < cnt) begin
      ctr_idx++;
      return 1'b0;
    end
    ctr_idx = 0;
    limit = 64'(cnt) << FRAC_SHIFT;
    if (pn <= EARLY_PASS_LAST) begin
      r.change = ONE_Q16;
    end else if (64'(pass_acc) > limit) begin
      delta = (pass_acc > last_pass_acc) ? 64'(pass_acc - last_pass_acc)
                                         : 64'(last_pass_acc - pass_acc);
      big = (pass_acc > last_pass_acc) ? 64'(pass_acc) : 64'(last_pass_acc);
      r.change = change_q16(delta, big);
    end else begin
      r.change = '0;
    end
    r.total = pass_acc;
    r.sat = (pass_acc == SUM_MAX);
    last_pass_acc = pass_acc;
    pass_acc = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    pass_result_t got;
    pass_result_t want;
    pass_result_t due;
    if (!rst_n) begin
      vec_len = VL_RESET;
      ctr_cnt = CC_RESET;
      ctr_thr = THR_RESET;
      elem_idx = 0;
      ctr_idx = 0;
      ctr_acc = '0;
      pass_acc = '0;
      last_pass_acc = '0;
      pass_results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_VECTOR_LENGTH:    vec_len = cfg_data[VL_W-1:0];
          CFG_CENTER_COUNT:     ctr_cnt = cfg_data[CC_W-1:0];
          CFG_CENTER_THRESHOLD: ctr_thr = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_convergence_sum, out_normalized_change, out_saturated};
        if (pass_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word: sum %0d change %0d sat %0d",
                     $realtime, got.total, got.change, got.sat);
        end else begin
          want = pass_results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: sum %0d/%0d change %0d/%0d sat %0d/%0d (exp/act)",
                       $realtime, want.total, got.total, want.change, got.change,
                       want.sat, got.sat);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (fold_coordinate(in_current_value, in_previous_value, in_pass_number, due))
          pass_results_due.push_back(due);
      end
    end
    pending = pass_results_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the convergence measure: clock, reset, stimulus, pacing and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kcm_pkg::*;

  localparam int MAX_LEN      = 32;
  localparam int MAX_CTR      = 64;
  localparam int RANDOM_WORDS = 750;
  localparam int SETTLE       = 40;
  localparam logic [VAL_W-1:0] VAL_MAX = 24'h7FFFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 24'h800000;
  localparam logic [THR_W-1:0] THR_TOP = {THR_W{1'b1}};

  logic                 clk                = 1'b0;
  logic                 rst_n              = 1'b0;
  logic                 in_valid           = 1'b0;
  logic [VAL_W-1:0]     in_current_value   = '0;
  logic [VAL_W-1:0]     in_previous_value  = '0;
  logic [PASS_W-1:0]    in_pass_number     = '0;
  logic                 out_stall          = 1'b0;
  logic                 cfg_wr_en          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index          = CFG_VECTOR_LENGTH;
  logic [THR_W-1:0]     cfg_data           = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [SUM_W-1:0]     out_convergence_sum;
  logic [CHG_W-1:0]     out_normalized_change;
  logic                 out_saturated;

  int mismatches;
  int pending;
  int words_sent = 0;
  int reg_len    = 16;
  int reg_cnt    = 64;
  bit calm_in    = 1'b0;
  bit calm_out   = 1'b0;

  always #10 clk = ~clk;

  kmeans_convergence_measure #(
    .MAX_VECTOR_LENGTH(MAX_LEN),
    .MAX_CENTERS      (MAX_CTR)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_current_value     (in_current_value),
    .in_previous_value    (in_previous_value),
    .in_pass_number       (in_pass_number),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_convergence_sum  (out_convergence_sum),
    .out_normalized_change(out_normalized_change),
    .out_saturated        (out_saturated),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  kcm_checker #(
    .MAX_LEN(MAX_LEN),
    .MAX_CTR(MAX_CTR)
  ) u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_current_value     (in_current_value),
    .in_previous_value    (in_previous_value),
    .in_pass_number       (in_pass_number),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_convergence_sum  (out_convergence_sum),
    .out_normalized_change(out_normalized_change),
    .out_saturated        (out_saturated),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .mismatches           (mismatches),
    .pending              (pending)
  );

  function automatic int effective(input int v, input int ceiling);
    return (v == 0) ? 1 : ((v > ceiling) ? ceiling : v);
  endfunction

  function automatic logic [VAL_W-1:0] corner();
    case ($urandom_range(0, 3))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_word(input logic [VAL_W-1:0] c, input logic [VAL_W-1:0] p,
                           input logic [PASS_W-1:0] n);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_current_value  <= c;
    in_previous_value <= p;
    in_pass_number    <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // hold the input idle until every pass result is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic make_pair(input int flavour, output logic [VAL_W-1:0] c,
                           output logic [VAL_W-1:0] p);
    int f;
    f = (flavour == 4) ? $urandom_range(0, 3) : flavour;
    case (f)
      0: begin
        p = VAL_W'($urandom);
        c = p;
      end
      1: begin
        p = VAL_W'($urandom);
        c = p + VAL_W'($urandom_range(0, 16383)) - VAL_W'(8192);
      end
      2: begin
        p = VAL_W'($urandom);
        c = VAL_W'($urandom);
      end
      default: begin
        p = corner();
        c = corner();
      end
    endcase
  endtask

  task automatic send_pass(input int words, input logic [PASS_W-1:0] pn, input int flavour);
    logic [VAL_W-1:0] c;
    logic [VAL_W-1:0] p;
    int               i;
    for (i = 0; i < words; i++) begin
      make_pair(flavour, c, p);
      send_word(c, p, (i == words - 1) ? pn : PASS_W'($urandom));
    end
  endtask

  initial begin : result_pacing
    int hold;
    wait (rst_n);
    forever begin
      hold = calm_out ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL kmeans_convergence_measure");
    $finish;
  end

  initial begin : stimulus
    logic [PASS_W-1:0] pn;
    logic [THR_W-1:0]  thr;
    logic [VAL_W-1:0]  c;
    logic [VAL_W-1:0]  p;
    int                per;
    int                passes;
    int                phase;
    int                k;
    int                new_len;
    int                new_cnt;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // zero length and count act as one, so every word closes a pass
    write_reg(CFG_VECTOR_LENGTH, '0);
    write_reg(CFG_CENTER_COUNT, '0);
    send_word(VAL_MAX, VAL_MIN, 16'd0);
    send_word(VAL_MIN, VAL_MAX, 16'd3);
    send_word(24'd0, 24'd0, 16'd3);
    send_word(24'd4096, 24'd0, 16'd7);
    send_word(24'd4097, 24'd0, 16'd7);
    send_word(24'hFFEC78, 24'd3000, 16'hFFFF);
    send_word(VAL_MIN, VAL_MIN, 16'd2);
    send_word(24'hFFFFFF, 24'd1, 16'd1);
    send_word(24'h555555, 24'hAAAAAA, 16'hAAAA);
    send_word(24'hAAAAAA, 24'h555555, 16'h5555);
    settle();
    write_reg(CFG_CENTER_THRESHOLD, '0);
    write_reg(CFG_VECTOR_LENGTH, THR_W'(2));
    write_reg(CFG_CENTER_COUNT, THR_W'(2));
    send_word(24'd1, 24'd0, 16'd9);
    send_word(24'd0, 24'd0, 16'd9);
    send_word(24'd0, 24'd0, 16'd9);
    send_word(24'd0, 24'd1, 16'd4);
    settle();
    // shorten the vector while three coordinates are already in
    write_reg(CFG_CENTER_THRESHOLD, THR_TOP);
    write_reg(CFG_VECTOR_LENGTH, THR_W'(4));
    write_reg(CFG_CENTER_COUNT, THR_W'(1));
    send_word(VAL_MAX, VAL_MIN, 16'd5);
    send_word(VAL_MIN, VAL_MAX, 16'd5);
    send_word(VAL_MAX, 24'd0, 16'd5);
    settle();
    write_reg(CFG_VECTOR_LENGTH, THR_W'(2));
    send_word(24'd0, VAL_MIN, 16'd6);
    settle();
    reg_len = 2;
    reg_cnt = 1;

    words_sent = 0;
    phase = 0;
    pn = '0;
    while (words_sent < RANDOM_WORDS) begin
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       new_len = 0;
        1:       new_len = 63;
        2:       new_len = MAX_LEN;
        3:       new_len = MAX_LEN + 1;
        default: new_len = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0:       new_cnt = 0;
        1:       new_cnt = 127;
        2:       new_cnt = MAX_CTR;
        3:       new_cnt = MAX_CTR + 1;
        default: new_cnt = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = THR_TOP;
        2:       thr = THR_W'(1) << 40;
        3:       thr = THR_RESET;
        4:       thr = THR_W'({$urandom, $urandom});
        default: thr = THR_W'($urandom_range(0, 32'h0FFF_FFFF));
      endcase
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        reg_len = new_len;
        write_reg(CFG_VECTOR_LENGTH, THR_W'(new_len));
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        reg_cnt = new_cnt;
        write_reg(CFG_CENTER_COUNT, THR_W'(new_cnt));
      end
      if (effective(reg_len, MAX_LEN) * effective(reg_cnt, MAX_CTR) > 128) begin
        reg_cnt = $urandom_range(1, 3);
        write_reg(CFG_CENTER_COUNT, THR_W'(reg_cnt));
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) write_reg(CFG_CENTER_THRESHOLD, thr);

      per = effective(reg_len, MAX_LEN) * effective(reg_cnt, MAX_CTR);
      passes = 60 / per + 1;
      case ($urandom_range(0, 3))
        0:       pn = '0;
        1:       pn = PASS_W'(3);
        2:       pn = PASS_W'($urandom);
        default: ;
      endcase
      for (k = 0; k < passes; k++) begin
        if (k == passes / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) drain();
        send_pass(per, pn, $urandom_range(0, 5) > 4 ? 4 : $urandom_range(0, 4));
        pn++;
      end
      // sometimes add up to one pass of words, so the next settings may meet running counters
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, per)) begin
          make_pair(4, c, p);
          send_word(c, p, PASS_W'($urandom));
        end
      end
      settle();
      phase++;
    end

    drain();
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS kmeans_convergence_measure");
    end else begin
      $display("FAIL kmeans_convergence_measure");
    end
    $finish;
  end

endmodule
